// ----- rtl/mi4_pkg.sv -----
// Shared types, widths and permutation tables for the 4x4 adjugate inverse.
// Used by mi4_ctrl, mi4_dp and matrix_inverse_4x4_adjugate_top.
package mi4_pkg;

	localparam int ELEM_W = 32;
	// Signed accumulator width: holds any determinant of a 4x4 Q16.16 matrix.
	localparam int ACC_W = 136;
	// Signed cofactor width: holds any 3x3 minor determinant.
	localparam int CF_W = 100;
	// Multiplicand magnitude is taken in 32-bit limbs.
	localparam int LIMB_N = 4;
	localparam int MAG_W = LIMB_N * ELEM_W;
	localparam int DIV_STEPS = 32;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_ACC_CLR,
		DP_PROD_SET,
		DP_MUL_START,
		DP_MUL_STEP,
		DP_MUL_END,
		DP_ACC_ADD,
		DP_CF_WR,
		DP_DET_WR,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] elem_idx;
		logic [3:0] cf_idx;
		logic       src_cf;
		logic [1:0] limb;
		logic       neg;
		logic [1:0] row;
		logic [1:0] col;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic det_zero;
	} dp_stat_t;

	// Column taken by minor row k under permutation p of a minor of size m.
	function automatic logic [1:0] perm_col(input logic [1:0] m, input logic [2:0] p,
			input logic [1:0] k);
		logic [1:0] res;
		res = k;
		case (m)
			2'd2: res = (p == 3'd1) ? (k ^ 2'd1) : k;
			2'd3: begin
				case (p)
					3'd0: res = k;
					3'd1: res = (k == 2'd0) ? 2'd0 : ((k == 2'd1) ? 2'd2 : 2'd1);
					3'd2: res = (k == 2'd0) ? 2'd1 : ((k == 2'd1) ? 2'd0 : 2'd2);
					3'd3: res = (k == 2'd0) ? 2'd1 : ((k == 2'd1) ? 2'd2 : 2'd0);
					3'd4: res = (k == 2'd0) ? 2'd2 : ((k == 2'd1) ? 2'd0 : 2'd1);
					3'd5: res = (k == 2'd0) ? 2'd2 : ((k == 2'd1) ? 2'd1 : 2'd0);
					default: res = k;
				endcase
			end
			default: res = 2'd0;
		endcase
		return res;
	endfunction

	// Odd permutations carry a minus sign.
	function automatic logic perm_neg(input logic [1:0] m, input logic [2:0] p);
		logic res;
		res = 1'b0;
		case (m)
			2'd2: res = (p == 3'd1);
			2'd3: res = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
			default: res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/mi4_ctrl.sv -----
// Sequencer for the adjugate inverse: loading, cofactors, determinant,
// division and output. Depends on mi4_pkg; drives mi4_dp by command words.
module mi4_ctrl
	import mi4_pkg::*;
#(
	parameter int N = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam int M = N - 1;
	localparam int NPERM = (M == 3) ? 6 : ((M == 2) ? 2 : 1);
	localparam logic [3:0] LAST_LOAD = 4'(N * N - 1);
	localparam logic [1:0] LAST_RC = 2'(N - 1);
	localparam logic [1:0] LAST_K = 2'(M - 1);
	localparam logic [2:0] LAST_P = 3'(NPERM - 1);

	typedef enum logic [3:0] {
		S_LOAD,
		S_CF_CLR,
		S_PERM_SET,
		S_MUL_START,
		S_MUL_STEP,
		S_MUL_END,
		S_PERM_ADD,
		S_CF_WR,
		S_DET_CLR,
		S_DET_ADD,
		S_DET_WR,
		S_DIV_INIT,
		S_DIV_STEP,
		S_OUT_SET,
		S_OUT_WAIT
	} state_t;

	state_t     state_q;
	logic [3:0] load_cnt_q;
	logic [1:0] cr_q;
	logic [1:0] cc_q;
	logic [2:0] p_q;
	logic [1:0] k_q;
	logic [1:0] limb_q;
	logic [4:0] step_q;
	logic       det_phase_q;
	logic       out_valid_q;

	logic [1:0] minor_j;
	logic [1:0] mrow;
	logic [1:0] mcol;
	logic [3:0] minor_idx;

	// Element of the current minor term, mapped back to the full matrix.
	always_comb begin
		minor_j   = perm_col(2'(M), p_q, k_q);
		mcol      = (minor_j < cc_q) ? minor_j : minor_j + 2'd1;
		mrow      = (k_q < cr_q) ? k_q : k_q + 2'd1;
		minor_idx = 4'(int'(mrow) * N + int'(mcol));
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = out_valid_q;

	// Command word for the datapath in the current state.
	always_comb begin
		cmd          = '0;
		cmd.op       = DP_NOP;
		cmd.elem_idx = det_phase_q ? 4'(cc_q) : minor_idx;
		cmd.cf_idx   = det_phase_q ? 4'(cc_q) : 4'(int'(cr_q) * N + int'(cc_q));
		cmd.src_cf   = det_phase_q;
		cmd.limb     = limb_q;
		cmd.row      = cr_q;
		cmd.col      = cc_q;
		cmd.last     = (cr_q == LAST_RC) && (cc_q == LAST_RC);
		case (state_q)
			S_LOAD: begin
				cmd.elem_idx = load_cnt_q;
				if (in_valid)
					cmd.op = DP_LOAD;
			end
			S_CF_CLR:    cmd.op = DP_ACC_CLR;
			S_DET_CLR:   cmd.op = DP_ACC_CLR;
			S_PERM_SET:  cmd.op = DP_PROD_SET;
			S_MUL_START: cmd.op = DP_MUL_START;
			S_MUL_STEP:  cmd.op = DP_MUL_STEP;
			S_MUL_END:   cmd.op = DP_MUL_END;
			S_PERM_ADD: begin
				cmd.op  = DP_ACC_ADD;
				cmd.neg = perm_neg(2'(M), p_q) ^ cr_q[0] ^ cc_q[0];
			end
			S_DET_ADD:   cmd.op = DP_ACC_ADD;
			S_CF_WR:     cmd.op = DP_CF_WR;
			S_DET_WR:    cmd.op = DP_DET_WR;
			S_DIV_INIT: begin
				// Inverse element (r, c) uses the cofactor of (c, r).
				cmd.cf_idx = 4'(int'(cc_q) * N + int'(cr_q));
				if (!stat.det_zero)
					cmd.op = DP_DIV_INIT;
			end
			S_DIV_STEP:  cmd.op = DP_DIV_STEP;
			S_OUT_SET:   cmd.op = DP_OUT;
			default:     cmd.op = DP_NOP;
		endcase
	end

	// State, counters and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			load_cnt_q  <= '0;
			cr_q        <= '0;
			cc_q        <= '0;
			p_q         <= '0;
			k_q         <= '0;
			limb_q      <= '0;
			step_q      <= '0;
			det_phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (load_cnt_q == LAST_LOAD) begin
							load_cnt_q  <= '0;
							cr_q        <= '0;
							cc_q        <= '0;
							det_phase_q <= 1'b0;
							state_q     <= S_CF_CLR;
						end else begin
							load_cnt_q <= load_cnt_q + 4'd1;
						end
					end
				end
				S_CF_CLR: begin
					p_q     <= '0;
					state_q <= S_PERM_SET;
				end
				S_PERM_SET: begin
					k_q     <= 2'd1;
					state_q <= (M == 1) ? S_PERM_ADD : S_MUL_START;
				end
				S_MUL_START: begin
					limb_q  <= '0;
					state_q <= S_MUL_STEP;
				end
				S_MUL_STEP: begin
					limb_q <= limb_q + 2'd1;
					if (limb_q == 2'(LIMB_N - 1))
						state_q <= S_MUL_END;
				end
				S_MUL_END: begin
					if (det_phase_q) begin
						state_q <= S_DET_ADD;
					end else if (k_q == LAST_K) begin
						state_q <= S_PERM_ADD;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_MUL_START;
					end
				end
				S_PERM_ADD: begin
					// The next term starts again from the first minor row.
					k_q <= '0;
					if (p_q == LAST_P) begin
						state_q <= S_CF_WR;
					end else begin
						p_q     <= p_q + 3'd1;
						state_q <= S_PERM_SET;
					end
				end
				S_CF_WR: begin
					if (cc_q == LAST_RC) begin
						cc_q <= '0;
						if (cr_q == LAST_RC) begin
							cr_q        <= '0;
							det_phase_q <= 1'b1;
							state_q     <= S_DET_CLR;
						end else begin
							cr_q    <= cr_q + 2'd1;
							state_q <= S_CF_CLR;
						end
					end else begin
						cc_q    <= cc_q + 2'd1;
						state_q <= S_CF_CLR;
					end
				end
				S_DET_CLR: state_q <= S_MUL_START;
				S_DET_ADD: begin
					if (cc_q == LAST_RC) begin
						cc_q    <= '0;
						state_q <= S_DET_WR;
					end else begin
						cc_q    <= cc_q + 2'd1;
						state_q <= S_MUL_START;
					end
				end
				S_DET_WR: state_q <= S_DIV_INIT;
				S_DIV_INIT: begin
					step_q  <= '0;
					state_q <= stat.det_zero ? S_OUT_SET : S_DIV_STEP;
				end
				S_DIV_STEP: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DIV_STEPS - 1))
						state_q <= S_OUT_SET;
				end
				S_OUT_SET: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (cc_q == LAST_RC) begin
							cc_q <= '0;
							if (cr_q == LAST_RC) begin
								cr_q        <= '0;
								det_phase_q <= 1'b0;
								state_q     <= S_LOAD;
							end else begin
								cr_q    <= cr_q + 2'd1;
								state_q <= S_DIV_INIT;
							end
						end else begin
							cc_q    <= cc_q + 2'd1;
							state_q <= S_DIV_INIT;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ----- rtl/mi4_dp.sv -----
// Datapath for the adjugate inverse: element and cofactor stores, limb
// multiplier, accumulator, restoring divider and output word registers.
// Depends on mi4_pkg; commanded by mi4_ctrl.
module mi4_dp
	import mi4_pkg::*;
(
	input  logic               clk,
	input  dp_cmd_t            cmd,
	input  logic signed [31:0] element_value,
	output dp_stat_t           stat,
	output logic signed [31:0] inverse_value,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic               singular,
	output logic               saturated,
	output logic               last_element
);

	logic [ELEM_W-1:0]       elem_q [16];
	logic signed [CF_W-1:0]  cf_q [16];
	logic signed [ACC_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] det_q;
	logic [MAG_W-1:0]        mul_a_q;
	logic [ELEM_W-1:0]       mul_b_q;
	logic [ACC_W-1:0]        mul_acc_q;
	logic                    mul_neg_q;
	logic [ACC_W-1:0]        rem_q;
	logic [ACC_W-1:0]        dmag_q;
	logic [31:0]             quo_q;
	logic                    qneg_q;
	logic                    qhi_q;

	logic [ELEM_W-1:0]       elem_rd;
	logic signed [ACC_W-1:0] elem_ext;
	logic signed [ACC_W-1:0] cf_ext;
	logic signed [ACC_W-1:0] src_val;
	logic [ACC_W-1:0]        src_mag;
	logic [ELEM_W-1:0]       elem_mag;
	logic [2*ELEM_W-1:0]     limb_prod;
	logic [ACC_W-1:0]        limb_term;
	logic [ACC_W:0]          rem_shift;
	logic [ACC_W-1:0]        cf_mag;
	logic [ACC_W-1:0]        det_mag;
	logic                    pos_sat;
	logic                    neg_sat;

	assign stat.det_zero = (det_q == '0);

	// Operand selection and magnitudes.
	always_comb begin
		elem_rd   = elem_q[cmd.elem_idx];
		elem_ext  = ACC_W'(signed'(elem_rd));
		cf_ext    = ACC_W'(cf_q[cmd.cf_idx]);
		src_val   = cmd.src_cf ? cf_ext : prod_q;
		src_mag   = src_val[ACC_W-1] ? ACC_W'(-src_val) : ACC_W'(src_val);
		elem_mag  = elem_rd[ELEM_W-1] ? (~elem_rd + 32'd1) : elem_rd;
		limb_prod = mul_a_q[32*cmd.limb +: 32] * mul_b_q;
		limb_term = ACC_W'(limb_prod) << (32 * int'(cmd.limb));
		rem_shift = {rem_q, 1'b0};
		cf_mag    = cf_ext[ACC_W-1] ? ACC_W'(-cf_ext) : ACC_W'(cf_ext);
		det_mag   = det_q[ACC_W-1] ? ACC_W'(-det_q) : ACC_W'(det_q);
		pos_sat   = qhi_q || quo_q[31];
		neg_sat   = qhi_q || (quo_q > 32'h8000_0000);
	end

	// Payload and arithmetic registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD:      elem_q[cmd.elem_idx] <= element_value;
			DP_ACC_CLR:   acc_q <= '0;
			DP_PROD_SET:  prod_q <= elem_ext;
			DP_MUL_START: begin
				mul_a_q   <= src_mag[MAG_W-1:0];
				mul_b_q   <= elem_mag;
				mul_neg_q <= src_val[ACC_W-1] ^ elem_rd[ELEM_W-1];
				mul_acc_q <= '0;
			end
			DP_MUL_STEP:  mul_acc_q <= mul_acc_q + limb_term;
			DP_MUL_END:   prod_q <= mul_neg_q ? -signed'(mul_acc_q) : signed'(mul_acc_q);
			DP_ACC_ADD:   acc_q <= cmd.neg ? acc_q - prod_q : acc_q + prod_q;
			DP_CF_WR:     cf_q[cmd.cf_idx] <= acc_q[CF_W-1:0];
			DP_DET_WR:    det_q <= acc_q;
			DP_DIV_INIT: begin
				// A quotient of 2^32 or more shows as cofactor >= determinant.
				rem_q  <= cf_mag;
				dmag_q <= det_mag;
				qneg_q <= cf_ext[ACC_W-1] ^ det_q[ACC_W-1];
				qhi_q  <= (cf_mag >= det_mag);
				quo_q  <= '0;
			end
			DP_DIV_STEP: begin
				if (rem_shift >= {1'b0, dmag_q}) begin
					rem_q <= ACC_W'(rem_shift - {1'b0, dmag_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_shift[ACC_W-1:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			DP_OUT: begin
				out_row      <= cmd.row;
				out_col      <= cmd.col;
				last_element <= cmd.last;
				singular     <= stat.det_zero;
				if (stat.det_zero) begin
					inverse_value <= '0;
					saturated     <= 1'b0;
				end else if (!qneg_q) begin
					inverse_value <= pos_sat ? 32'sh7FFF_FFFF : signed'(quo_q);
					saturated     <= pos_sat;
				end else begin
					inverse_value <= neg_sat ? 32'sh8000_0000 : signed'(-quo_q);
					saturated     <= neg_sat;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/matrix_inverse_4x4_adjugate_top.sv -----
// 4x4 matrix inverse by cofactors and adjugate: top level.
// Instantiates mi4_ctrl and mi4_dp; depends on mi4_pkg.
//
// Usage:
// - Input channel (in_valid/in_ready, element_value) takes the N*N matrix
//   words in row-major order, signed Q16.16, one word per cycle while loading.
// - After the last word the block computes all cofactors, the determinant,
//   and then one quotient per inverse element; in_ready stays low until all
//   N*N result words have been taken.
// - Output channel (out_valid/out_ready) gives the inverse in row-major
//   order with its row and column, singular, saturated and last_element.
// - For N = 4 every cofactor term and the determinant go through the shared
//   32x32 limb multiplier, four limbs per product. Each output word then
//   takes setup, 32 divider steps (skipped when the matrix is singular),
//   the output register and the handshake.
// - A stalled receiver holds the current word; the sequencer waits.
// - Reset returns the block to loading with an empty word count.
module matrix_inverse_4x4_adjugate_top
	import mi4_pkg::*;
#(
	parameter int MATRIX_SIZE = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] element_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] inverse_value,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic               singular,
	output logic               saturated,
	output logic               last_element
);

	localparam int N = (MATRIX_SIZE < 2) ? 2 : ((MATRIX_SIZE > 4) ? 4 : MATRIX_SIZE);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mi4_ctrl #(
		.N(N)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mi4_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.element_value (element_value),
		.stat          (stat),
		.inverse_value (inverse_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.singular      (singular),
		.saturated     (saturated),
		.last_element  (last_element)
	);

endmodule

// ----- test/tb_matrix_inverse_4x4_adjugate_top.sv -----
// Testbench for matrix_inverse_4x4_adjugate_top: loads 4x4 Q16.16 matrices word by word
// and checks every inverse word against a cofactor/adjugate predictor held here (random
// matrices) or typed expectations (directed). Depends on mi4_pkg and the RTL only.
module tb_matrix_inverse_4x4_adjugate_top;
	import mi4_pkg::*;

	localparam int CYCLE_LIMIT = 900000;
	localparam int RANDOM_MATRICES = 14;
	localparam int DIR_MATRICES = 2;

	// Kinds of matrices: typed expectations for directed ones, shapes for random ones.
	typedef enum int {
		MK_SINGULAR, MK_DIAG_SAT, MK_FULL, MK_NEAR_IDENT, MK_SMALL_INT, MK_DUP_ROW
	} mat_kind_t;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         row;
		logic [1:0]         col;
		logic               sing;
		logic               sat;
		logic               last;
	} inv_word_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] element_value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] inverse_value;
	logic [1:0]         out_row;
	logic [1:0]         out_col;
	logic               singular;
	logic               saturated;
	logic               last_element;

	inv_word_t          inverse_q[$];
	logic signed [31:0] matrix [16];
	int                 errors;
	int                 words_checked;
	int                 singular_seen;
	int                 saturated_seen;
	int                 cycles;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	matrix_inverse_4x4_adjugate_top #(.MATRIX_SIZE(4)) u_top (.*);

	// Clock with period 12.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Cycle counter and timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h (word %0d)", what, got, want,
			words_checked);
		errors++;
	endtask

	// Signed cofactor of (row, col) in the current matrix, exact.
	function automatic wide_t cofactor(input int row, input int col);
		wide_t a [9];
		wide_t d;
		int k;
		k = 0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (r != row && c != col) begin
					a[k] = matrix[r * 4 + c];
					k++;
				end
			end
		end
		d = a[0] * (a[4] * a[8] - a[5] * a[7]) - a[1] * (a[3] * a[8] - a[5] * a[6])
			+ a[2] * (a[3] * a[7] - a[4] * a[6]);
		return ((row + col) % 2 == 1) ? -d : d;
	endfunction

	// Predict all sixteen inverse words of the current matrix.
	task automatic predict_inverse();
		wide_t det;
		wide_t cf;
		logic [191:0] num;
		logic [191:0] den;
		logic [191:0] quo;
		logic neg;
		inv_word_t w;
		det = 0;
		for (int j = 0; j < 4; j++) det += wide_t'(matrix[j]) * cofactor(0, j);
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				w.row = r[1:0];
				w.col = c[1:0];
				w.sing = (det == 0);
				w.sat = 1'b0;
				w.value = '0;
				w.last = (r == 3 && c == 3);
				if (det != 0) begin
					cf = cofactor(c, r);
					neg = cf[191] != det[191];
					num = (cf[191] ? -cf : cf) << 32;
					den = det[191] ? -det : det;
					quo = num / den;
					if (!neg) begin
						if (|quo[191:32] || quo[31:0] > 32'h7FFF_FFFF) begin
							w.value = 32'h7FFF_FFFF;
							w.sat = 1'b1;
						end else w.value = quo[31:0];
					end else begin
						if (|quo[191:32] || quo[31:0] > 32'h8000_0000) begin
							w.value = 32'h8000_0000;
							w.sat = 1'b1;
						end else w.value = -quo[31:0];
					end
				end
				inverse_q.push_back(w);
			end
		end
	endtask

	// Expectations read straight off the matrix: all zero when singular, or a
	// diagonal of tiny values whose inverse clips at every diagonal word.
	task automatic push_typed(input mat_kind_t kind);
		inv_word_t w;
		for (int k = 0; k < 16; k++) begin
			w.row = 2'(k / 4);
			w.col = 2'(k % 4);
			w.last = (k == 15);
			w.sing = (kind == MK_SINGULAR);
			w.sat = (kind == MK_DIAG_SAT) && (k % 5 == 0);
			w.value = '0;
			if (w.sat) w.value = matrix[k][31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			inverse_q.push_back(w);
		end
	endtask

	// Send one word, with a random gap first, and wait for acceptance.
	task automatic send_word(input logic signed [31:0] v);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Send the held matrix, then record what it should produce.
	task automatic send_matrix(input mat_kind_t kind, input bit typed);
		for (int k = 0; k < 16; k++) send_word(matrix[k]);
		if (typed) push_typed(kind);
		else predict_inverse();
	endtask

	// Fill the matrix with random content of the given shape.
	task automatic build_matrix(input mat_kind_t kind);
		int src;
		int dst;
		for (int k = 0; k < 16; k++) begin
			case (kind)
				MK_NEAR_IDENT: begin
					matrix[k] = int'($urandom_range(0, 32767)) - 16384;
					if (k % 5 == 0) matrix[k] += 65536;
				end
				MK_SMALL_INT: matrix[k] = (int'($urandom_range(0, 6)) - 3) * 65536;
				MK_DIAG_SAT: matrix[k] = (k % 5 == 0) ?
					(int'($urandom_range(1, 200)) * ($urandom_range(0, 1) ? -1 : 1)) : 0;
				default: matrix[k] = $urandom;
			endcase
		end
		if (kind == MK_DUP_ROW) begin
			src = $urandom_range(0, 3);
			dst = (src + $urandom_range(1, 3)) % 4;
			for (int c = 0; c < 4; c++) matrix[dst * 4 + c] = matrix[src * 4 + c];
		end
	endtask

	// Receiver: check each accepted word, then draw the next stall.
	always @(posedge clk) begin
		inv_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (inverse_q.size() == 0) begin
				$display("unexpected inverse word at row %0d col %0d", out_row, out_col);
				errors++;
			end else begin
				w = inverse_q.pop_front();
				if (inverse_value !== w.value) report_mismatch("value", inverse_value, w.value);
				if (out_row !== w.row) report_mismatch("row", out_row, w.row);
				if (out_col !== w.col) report_mismatch("col", out_col, w.col);
				if (singular !== w.sing) report_mismatch("singular", singular, w.sing);
				if (saturated !== w.sat) report_mismatch("saturated", saturated, w.sat);
				if (last_element !== w.last) report_mismatch("last", last_element, w.last);
				singular_seen += w.sing;
				saturated_seen += w.sat;
			end
			words_checked++;
		end
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Directed matrices: a singular one built from extreme words, and a
	// diagonal of raw ones whose inverse clips both ways.
	logic signed [31:0] dir_words [DIR_MATRICES * 16] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004,
		32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0001_0000,
		32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
		32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
		32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
		32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001
	};
	mat_kind_t dir_kinds [DIR_MATRICES] = '{MK_SINGULAR, MK_DIAG_SAT};

	// Main sequence: reset, directed matrices, three idling phases of random ones.
	initial begin
		mat_kind_t kind;
		int guard;
		errors = 0;
		words_checked = 0;
		singular_seen = 0;
		saturated_seen = 0;
		send_idle_pct = 24;
		recv_idle_pct = 87;
		arst_n = 1'b0;
		in_valid = 1'b0;
		element_value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int m = 0; m < DIR_MATRICES; m++) begin
			for (int k = 0; k < 16; k++) matrix[k] = dir_words[m * 16 + k];
			send_matrix(dir_kinds[m], 1'b1);
		end

		for (int m = 0; m < RANDOM_MATRICES; m++) begin
			if (m == RANDOM_MATRICES / 3) begin
				send_idle_pct = 87;
				recv_idle_pct = 24;
			end else if (m == 2 * RANDOM_MATRICES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			kind = mat_kind_t'($urandom_range(MK_DIAG_SAT, MK_DUP_ROW));
			build_matrix(kind);
			send_matrix(kind, 1'b0);
		end
		in_valid <= 1'b0;

		// Drain the outstanding words, then leave room for stray output.
		guard = 0;
		while (inverse_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		if (inverse_q.size() != 0) begin
			$display("%0d inverse words never arrived", inverse_q.size());
			errors++;
		end

		$display("%0d matrices, %0d inverse words checked (%0d singular, %0d clipped)",
			DIR_MATRICES + RANDOM_MATRICES, words_checked, singular_seen, saturated_seen);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mi4_pkg.sv
rtl/mi4_ctrl.sv
rtl/mi4_dp.sv
rtl/matrix_inverse_4x4_adjugate_top.sv
test/tb_matrix_inverse_4x4_adjugate_top.sv
